[sv/ulv_pkg.sv]
package ulv_pkg;

  // Field widths fixed by the label format.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CountW  = 17;
  localparam int unsigned CpW     = 21;
  localparam int unsigned ReasonW = 3;

  // Register reset value and saturation limit of the byte count.
  localparam logic [LenW-1:0]   MaxLenReset = 16'd512;
  localparam logic [CountW-1:0] CountMax    = 17'h1ffff;

  // Verdict codes; the checker ranks Empty, TooLong, BadUtf8, Control, then Ok.
  typedef enum logic [ReasonW-1:0] {
    ReasonOk      = 3'd0,
    ReasonEmpty   = 3'd1,
    ReasonTooLong = 3'd2,
    ReasonBadUtf8 = 3'd3,
    ReasonControl = 3'd4
  } reason_e;

  // One input transfer.
  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             has_byte;
    logic             last;
  } in_item_t;

  // One verdict transfer.
  typedef struct packed {
    logic               label_ok;
    logic               utf8_ok;
    logic [ReasonW-1:0] reason;
  } out_item_t;

  // Verdict handed from the checker to the output buffer.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } verdict_t;

endpackage

[sv/ulv_check.sv]
module ulv_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  ulv_pkg::in_item_t            item_i,
  input  logic [ulv_pkg::LenW-1:0]     max_length_i,
  output ulv_pkg::verdict_t            verdict_o
);
  import ulv_pkg::*;

  // Per-label decoder state.
  logic [1:0]        pend_q, pend_d;
  logic [1:0]        seq_len_q, seq_len_d;
  logic [CpW-1:0]    cp_q, cp_d;
  logic              utf_err_q, utf_err_d;
  logic              ctrl_q, ctrl_d;
  logic [CountW-1:0] count_q, count_d;

  logic [ByteW-1:0]  b;
  logic [CpW-1:0]    cp_next;
  logic              cp_bad;
  logic              utf_ok;
  reason_e           reason;

  assign b       = item_i.text_byte;
  assign cp_next = {cp_q[CpW-7:0], b[5:0]};

  // A finished sequence is bad if it is overlong, a surrogate or out of range.
  always_comb begin
    cp_bad = 1'b0;
    if (seq_len_q == 2'd1 && cp_next < CpW'(32'h80)) cp_bad = 1'b1;
    if (seq_len_q == 2'd2 && cp_next < CpW'(32'h800)) cp_bad = 1'b1;
    if (seq_len_q == 2'd3 && cp_next < CpW'(32'h10000)) cp_bad = 1'b1;
    if (cp_next > CpW'(32'h10ffff)) cp_bad = 1'b1;
    if (cp_next >= CpW'(32'hd800) && cp_next <= CpW'(32'hdfff)) cp_bad = 1'b1;
  end

  // Byte step: counts, flags and the UTF-8 decoder.
  always_comb begin
    pend_d    = pend_q;
    seq_len_d = seq_len_q;
    cp_d      = cp_q;
    utf_err_d = utf_err_q;
    ctrl_d    = ctrl_q;
    count_d   = count_q;
    if (item_i.has_byte) begin
      if (count_q != CountMax) count_d = count_q + CountW'(1);
      if (b < 8'h20) ctrl_d = 1'b1;
      if (pend_q == 2'd0) begin
        priority if (b[7] == 1'b0) begin
          // Plain ASCII byte, nothing to track.
        end else if (b[7:5] == 3'b110) begin
          seq_len_d = 2'd1;
          pend_d    = 2'd1;
          cp_d      = CpW'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          seq_len_d = 2'd2;
          pend_d    = 2'd2;
          cp_d      = CpW'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
          seq_len_d = 2'd3;
          pend_d    = 2'd3;
          cp_d      = CpW'(b[2:0]);
        end else begin
          utf_err_d = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        // Broken sequence: drop it; this byte is not a new lead.
        utf_err_d = 1'b1;
        pend_d    = 2'd0;
        seq_len_d = 2'd0;
        cp_d      = '0;
      end else begin
        pend_d = pend_q - 2'd1;
        cp_d   = cp_next;
        if (pend_q == 2'd1) begin
          if (cp_bad) utf_err_d = 1'b1;
          seq_len_d = 2'd0;
          cp_d      = '0;
        end
      end
    end
  end

  // Verdict from the state after this byte.
  always_comb begin
    utf_ok = !utf_err_d && (pend_d == 2'd0);
    priority if (count_d == '0) begin
      reason = ReasonEmpty;
    end else if (count_d > CountW'(max_length_i)) begin
      reason = ReasonTooLong;
    end else if (!utf_ok) begin
      reason = ReasonBadUtf8;
    end else if (ctrl_d) begin
      reason = ReasonControl;
    end else begin
      reason = ReasonOk;
    end
  end

  assign verdict_o.valid         = accept_i && item_i.last;
  assign verdict_o.item.label_ok = (reason == ReasonOk);
  assign verdict_o.item.utf8_ok  = utf_ok;
  assign verdict_o.item.reason   = reason;

  // State update; the last item of a label clears everything.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      seq_len_q <= '0;
      cp_q      <= '0;
      utf_err_q <= 1'b0;
      ctrl_q    <= 1'b0;
      count_q   <= '0;
    end else if (accept_i) begin
      if (item_i.last) begin
        pend_q    <= '0;
        seq_len_q <= '0;
        cp_q      <= '0;
        utf_err_q <= 1'b0;
        ctrl_q    <= 1'b0;
        count_q   <= '0;
      end else begin
        pend_q    <= pend_d;
        seq_len_q <= seq_len_d;
        cp_q      <= cp_d;
        utf_err_q <= utf_err_d;
        ctrl_q    <= ctrl_d;
        count_q   <= count_d;
      end
    end
  end

endmodule

[sv/utf8_label_validator_top.sv]
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_data_i  (text_byte, has_byte, last)
// out       output     out_valid_o / out_stall_i out_data_o (label_ok, utf8_ok, reason)
// cfg       input      cfg_we_i                  cfg_wdata_i (max_length)
//
// One byte is taken every cycle while in_stall_o is low; the decoder state is registered per byte.
// A label's verdict goes into the output register, or into the skid entry while that is held.
// The output register plus one skid entry hold verdicts; input stalls only when both are full.
// Reset clears the label state and sets max_length to 512.
module utf8_label_validator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ulv_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ulv_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [ulv_pkg::LenW-1:0]     cfg_wdata_i
);
  import ulv_pkg::*;

  logic [LenW-1:0] max_len_q;
  logic            in_acc;
  logic            out_pop;
  verdict_t        verdict;
  logic            out_valid_q, skid_valid_q;
  out_item_t       out_q, skid_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_pop = out_valid_q && !out_stall_i;

  // Length limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  ulv_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_acc),
    .item_i       (in_data_i),
    .max_length_i (max_len_q),
    .verdict_o    (verdict)
  );

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (verdict.valid) begin
      if (!out_valid_q || out_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Verdict payloads.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) out_q <= skid_q;
    end else if (verdict.valid) begin
      if (!out_valid_q || out_pop) begin
        out_q <= verdict.item;
      end else begin
        skid_q <= verdict.item;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A filled skid entry always sits behind a filled output register.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // label_ok agrees with the reason code.
  a_ok_matches_reason : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.label_ok == (out_data_o.reason == ReasonOk)))
    else $error("label_ok disagrees with reason");

  // Malformed UTF-8 can only be reported as too long or bad UTF-8.
  a_utf_reason : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.utf8_ok) |->
      (out_data_o.reason == ReasonTooLong || out_data_o.reason == ReasonBadUtf8))
    else $error("utf8_ok low with unrelated reason");

  // An ending transfer with free output space shows up next cycle.
  a_verdict_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last && !out_valid_q) |=> out_valid_o)
    else $error("verdict did not reach the output");

endmodule
